// ===== hw/rtl/ifsf_pkg.sv =====
package ifsf_pkg;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_FLAG  = 8'h5E;
	localparam logic [7:0] ESC_ESC   = 8'h5D;

	localparam int QUEUE_DEPTH = 2;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [1:0] REG_ADDRESS   = 2'd0;
	localparam logic [1:0] REG_CTRL_SEQ0 = 2'd1;
	localparam logic [1:0] REG_CTRL_SEQ1 = 2'd2;

	localparam logic [7:0] ADDRESS_RST   = 8'd3;
	localparam logic [7:0] CTRL_SEQ0_RST = 8'd0;
	localparam logic [7:0] CTRL_SEQ1_RST = 8'd64;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       seq_bit;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
	} out_item_t;

	typedef struct packed {
		logic [7:0] address_byte;
		logic [7:0] control_seq0;
		logic [7:0] control_seq1;
	} cfg_t;

	typedef struct packed {
		logic       header;
		logic [7:0] address;
		logic [7:0] control;
		logic [7:0] data;
		logic       last;
		logic [7:0] check;
	} job_t;

	function automatic logic needs_escape(input logic [7:0] b);
		return (b == FLAG_BYTE) || (b == ESC_BYTE);
	endfunction

	function automatic logic [7:0] escaped_byte(input logic [7:0] b);
		return (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
	endfunction

endpackage

// ===== hw/rtl/ifsf_front.sv =====
module ifsf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  ifsf_pkg::in_item_t in_item,
	input  ifsf_pkg::cfg_t     cfg,
	output ifsf_pkg::job_t     job
);
	import ifsf_pkg::*;

	logic       inside_frame_q;
	logic [7:0] running_check_q;
	logic [7:0] check;

	always_comb begin
		check = inside_frame_q ? (running_check_q ^ in_item.data_byte) : in_item.data_byte;
		job.header  = !inside_frame_q;
		job.address = cfg.address_byte;
		job.control = in_item.seq_bit ? cfg.control_seq1 : cfg.control_seq0;
		job.data    = in_item.data_byte;
		job.last    = in_item.last_byte;
		job.check   = check;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_frame_q  <= 1'b0;
			running_check_q <= 8'd0;
		end else if (accept) begin
			if (in_item.last_byte) begin
				inside_frame_q  <= 1'b0;
				running_check_q <= 8'd0;
			end else begin
				inside_frame_q  <= 1'b1;
				running_check_q <= check;
			end
		end
	end

endmodule

// ===== hw/rtl/ifsf_queue.sv =====
module ifsf_queue #(
	parameter int DEPTH = ifsf_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ifsf_pkg::job_t push_job,
	input  logic           pop,
	output ifsf_pkg::job_t head,
	output logic           empty,
	output logic           full
);
	import ifsf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == FULL_CNT);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_CNT)
		else $error("Queue count exceeds its depth.");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("Queue popped while empty.");
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("Queue pushed while full.");

endmodule

// ===== hw/rtl/ifsf_back.sv =====
module ifsf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ifsf_pkg::job_t      head,
	input  logic                empty,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output ifsf_pkg::out_item_t out_item
);
	import ifsf_pkg::*;

	typedef enum logic [3:0] {
		PH_FLAG,
		PH_ADDR,
		PH_CTRL,
		PH_HCHK,
		PH_DATA,
		PH_DATA_ESC,
		PH_CHK,
		PH_CHK_ESC,
		PH_CLOSE
	} phase_t;

	phase_t    phase_q;
	logic      busy_q;
	logic      out_valid_q;
	out_item_t out_item_q;

	phase_t    cur_phase;
	phase_t    next_phase;
	out_item_t emit;
	logic      advance;

	assign advance = !empty && (!out_valid_q || out_ready);
	assign pop     = advance && emit.run_last;

	always_comb begin
		cur_phase      = busy_q ? phase_q : (head.header ? PH_FLAG : PH_DATA);
		next_phase     = cur_phase;
		emit.out_byte  = FLAG_BYTE;
		emit.run_last  = 1'b0;
		emit.frame_end = 1'b0;
		unique case (cur_phase)
			PH_FLAG: begin
				emit.out_byte = FLAG_BYTE;
				next_phase    = PH_ADDR;
			end
			PH_ADDR: begin
				emit.out_byte = head.address;
				next_phase    = PH_CTRL;
			end
			PH_CTRL: begin
				emit.out_byte = head.control;
				next_phase    = PH_HCHK;
			end
			PH_HCHK: begin
				emit.out_byte = head.address ^ head.control;
				next_phase    = PH_DATA;
			end
			PH_DATA: begin
				if (needs_escape(head.data)) begin
					emit.out_byte = ESC_BYTE;
					next_phase    = PH_DATA_ESC;
				end else begin
					emit.out_byte = head.data;
					next_phase    = PH_CHK;
					emit.run_last = !head.last;
				end
			end
			PH_DATA_ESC: begin
				emit.out_byte = escaped_byte(head.data);
				next_phase    = PH_CHK;
				emit.run_last = !head.last;
			end
			PH_CHK: begin
				if (needs_escape(head.check)) begin
					emit.out_byte = ESC_BYTE;
					next_phase    = PH_CHK_ESC;
				end else begin
					emit.out_byte = head.check;
					next_phase    = PH_CLOSE;
				end
			end
			PH_CHK_ESC: begin
				emit.out_byte = escaped_byte(head.check);
				next_phase    = PH_CLOSE;
			end
			PH_CLOSE: begin
				emit.out_byte  = FLAG_BYTE;
				emit.run_last  = 1'b1;
				emit.frame_end = 1'b1;
			end
			default: begin
				emit.out_byte = FLAG_BYTE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FLAG;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				out_item_q  <= emit;
				busy_q      <= !emit.run_last;
				phase_q     <= next_phase;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> !empty)
		else $error("Sequencer is mid-item with no item at the queue head.");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_item_q.frame_end && out_valid_q |->
		out_item_q.run_last && (out_item_q.out_byte == FLAG_BYTE))
		else $error("Closing flag is malformed.");
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (phase_q == PH_CLOSE) |-> head.last)
		else $error("Closing flag reached on an item that does not end the frame.");

endmodule

// ===== hw/rtl/info_frame_stuffing_framer.sv =====
// An accepted item goes into the item queue; its line bytes leave through the back sequencer's
// single output register, one per cycle while the queue holds an item and out_ready is high. An
// item yields 1 to 9 line bytes: one for a plain mid-frame byte, two for an escaped one, plus
// four for the header of a first byte and two or three for the check and closing flag of a last
// one. Reset clears the frame state, the item queue and output; registers take their defaults.
module info_frame_stuffing_framer #(
	parameter int QUEUE_DEPTH = ifsf_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  ifsf_pkg::in_item_t                  in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output ifsf_pkg::out_item_t                 out_item,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ifsf_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [ifsf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [ifsf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import ifsf_pkg::*;

	cfg_t       cfg_q;
	logic       cfg_write;
	logic [1:0] reg_idx;
	logic       in_accept;
	logic       q_full;
	logic       q_empty;
	logic       q_pop;
	job_t       front_job;
	job_t       head_job;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.address_byte <= ADDRESS_RST;
			cfg_q.control_seq0 <= CTRL_SEQ0_RST;
			cfg_q.control_seq1 <= CTRL_SEQ1_RST;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_ADDRESS:   cfg_q.address_byte <= pwdata[7:0];
				REG_CTRL_SEQ0: cfg_q.control_seq0 <= pwdata[7:0];
				REG_CTRL_SEQ1: cfg_q.control_seq1 <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_ADDRESS:   prdata[7:0] = cfg_q.address_byte;
			REG_CTRL_SEQ0: prdata[7:0] = cfg_q.control_seq0;
			REG_CTRL_SEQ1: prdata[7:0] = cfg_q.control_seq1;
			default:       prdata      = '0;
		endcase
	end

	assign in_ready  = !q_full;
	assign in_accept = in_valid && in_ready;

	ifsf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_accept),
		.in_item (in_item),
		.cfg     (cfg_q),
		.job     (front_job)
	);

	ifsf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_accept),
		.push_job (front_job),
		.pop      (q_pop),
		.head     (head_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	ifsf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_job),
		.empty     (q_empty),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== tb/info_frame_stuffing_framer_tb.sv =====
`timescale 1ns / 1ps

module info_frame_stuffing_framer_tb;
	import ifsf_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_CYCLES = 100;
	localparam int PHASE_ITEMS = 54;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_item;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_item;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	in_item_t  feed[$];
	out_item_t line_expect[$];
	out_item_t burst[9];
	int        burst_len;
	cfg_t      shadow;
	logic      in_frame;
	logic [7:0] frame_check;

	int   tx_gap;
	int   rx_gap;
	logic tx_idle_on;
	logic rx_idle_on;
	logic hold_out;
	int   quiet_cycles;
	int   fail_count;

	info_frame_stuffing_framer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void emit(input logic [7:0] b, input logic fe);
		out_item_t r;
		r.out_byte = b;
		r.run_last = 1'b0;
		r.frame_end = fe;
		burst[burst_len] = r;
		burst_len++;
	endfunction

	function automatic void emit_stuffed(input logic [7:0] b);
		if (b == FLAG_BYTE) begin
			emit(ESC_BYTE, 1'b0);
			emit(ESC_FLAG, 1'b0);
		end else if (b == ESC_BYTE) begin
			emit(ESC_BYTE, 1'b0);
			emit(ESC_ESC, 1'b0);
		end else begin
			emit(b, 1'b0);
		end
	endfunction

	function automatic void predict_line(input in_item_t it);
		logic [7:0] ctl;
		burst_len = 0;
		if (!in_frame) begin
			ctl = it.seq_bit ? shadow.control_seq1 : shadow.control_seq0;
			emit(FLAG_BYTE, 1'b0);
			emit(shadow.address_byte, 1'b0);
			emit(ctl, 1'b0);
			emit(shadow.address_byte ^ ctl, 1'b0);
			in_frame = 1'b1;
			frame_check = 8'h00;
		end
		emit_stuffed(it.data_byte);
		frame_check = frame_check ^ it.data_byte;
		if (it.last_byte) begin
			emit_stuffed(frame_check);
			emit(FLAG_BYTE, 1'b1);
			in_frame = 1'b0;
			frame_check = 8'h00;
		end
		burst[burst_len - 1].run_last = 1'b1;
		for (int i = 0; i < burst_len; i++)
			line_expect.push_back(burst[i]);
	endfunction

	always @(posedge clk) begin : drive_proc
		logic next_valid;
		next_valid = in_valid;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_line(in_item);
				next_valid = 1'b0;
				tx_gap = tx_idle_on ? $urandom_range(0, 13) : 0;
			end
			if (!next_valid) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (feed.size() > 0) begin
					in_item <= feed.pop_front();
					next_valid = 1'b1;
				end
			end
			in_valid <= next_valid;
		end
	end

	always @(posedge clk) begin : check_proc
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (line_expect.size() == 0) begin
					$display("%0t: unexpected line byte %h run_last %b frame_end %b", $time,
						out_item.out_byte, out_item.run_last, out_item.frame_end);
					fail_count++;
				end else begin
					want = line_expect.pop_front();
					if (out_item.out_byte !== want.out_byte ||
							out_item.run_last !== want.run_last ||
							out_item.frame_end !== want.frame_end) begin
						$display("%0t: expected byte %h run_last %b frame_end %b, got %h %b %b",
							$time, want.out_byte, want.run_last, want.frame_end,
							out_item.out_byte, out_item.run_last, out_item.frame_end);
						fail_count++;
					end
				end
				rx_gap = rx_idle_on ? $urandom_range(0, 13) : 0;
			end
			if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !hold_out;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles == QUIET_LIMIT) begin
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
		logic [APB_DATA_W-1:0] wdata;
		wdata = $urandom();
		wdata[7:0] = val;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ADDRESS:   shadow.address_byte = val;
			REG_CTRL_SEQ0: shadow.control_seq0 = val;
			REG_CTRL_SEQ1: shadow.control_seq1 = val;
			default: ;
		endcase
	endtask

	task automatic set_framer_regs(input logic [7:0] a, input logic [7:0] c0,
			input logic [7:0] c1);
		reg_write(REG_ADDRESS, a);
		reg_write(REG_CTRL_SEQ0, c0);
		reg_write(REG_CTRL_SEQ1, c1);
	endtask

	task automatic queue_item(input logic [7:0] b, input logic last, input logic seq);
		in_item_t it;
		it.data_byte = b;
		it.last_byte = last;
		it.seq_bit = seq;
		feed.push_back(it);
	endtask

	// Mostly short frames, now and then a long one; escape-worthy bytes are made common.
	task automatic queue_random_frames(input int count);
		int left;
		int flen;
		logic [7:0] b;
		left = count;
		while (left > 0) begin
			flen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
			if (flen > left)
				flen = left;
			for (int k = 0; k < flen; k++) begin
				case ($urandom_range(0, 7))
					0: b = FLAG_BYTE;
					1: b = ESC_BYTE;
					default: b = 8'($urandom_range(0, 255));
				endcase
				queue_item(b, k == flen - 1, 1'($urandom_range(0, 1)));
			end
			left -= flen;
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (feed.size() != 0 || in_valid || line_expect.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		shadow.address_byte = ADDRESS_RST;
		shadow.control_seq0 = CTRL_SEQ0_RST;
		shadow.control_seq1 = CTRL_SEQ1_RST;
		in_frame = 1'b0;
		frame_check = 8'h00;
		tx_gap = 0;
		rx_gap = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		hold_out = 1'b0;
		quiet_cycles = 0;
		fail_count = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Reset values first: one-byte frames, escaped payload and check bytes,
		// and a sequence bit that changes in mid-frame.
		queue_item(8'h00, 1'b1, 1'b0);
		queue_item(8'hFF, 1'b1, 1'b1);
		queue_item(FLAG_BYTE, 1'b1, 1'b0);
		queue_item(ESC_BYTE, 1'b1, 1'b1);
		queue_item(8'h12, 1'b0, 1'b1);
		queue_item(8'h6C, 1'b1, 1'b0);
		queue_item(FLAG_BYTE, 1'b0, 1'b0);
		queue_item(ESC_BYTE, 1'b0, 1'b1);
		queue_item(8'h55, 1'b0, 1'b0);
		queue_item(8'hAA, 1'b0, 1'b1);
		queue_item(8'h01, 1'b1, 1'b1);
		queue_item(8'h80, 1'b0, 1'b1);
		queue_item(8'h7C, 1'b0, 1'b0);
		queue_item(8'h7F, 1'b1, 1'b0);
		wait_drained();

		for (int ph = 1; ph <= 5; ph++) begin
			case (ph)
				1: set_framer_regs(8'h00, 8'h00, 8'h00);
				2: set_framer_regs(8'hFF, 8'hFF, 8'hFF);
				3: set_framer_regs(FLAG_BYTE, ESC_BYTE, FLAG_BYTE);
				4: set_framer_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
				default: begin
					set_framer_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
					reg_write(REG_UNUSED, 8'($urandom_range(0, 255)));
				end
			endcase
			@(negedge clk);
			tx_idle_on = (ph == 2) || (ph == 3) || (ph == 5);
			rx_idle_on = (ph == 2) || (ph == 4) || (ph == 5);
			queue_random_frames(PHASE_ITEMS);
			if (ph == 2) begin
				@(posedge clk);
				hold_out <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_out <= 1'b0;
			end
			wait_drained();
		end

		repeat (10) @(negedge clk);
		if (fail_count == 0 && line_expect.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/ifsf_pkg.sv
hw/rtl/ifsf_front.sv
hw/rtl/ifsf_queue.sv
hw/rtl/ifsf_back.sv
hw/rtl/info_frame_stuffing_framer.sv
tb/info_frame_stuffing_framer_tb.sv
